// ----- hw/rtl/ouis_pkg.sv -----
// Package for the ordered unique index set: sizes, operation codes,
// result status codes and the control bundle passed from the sequencer to the cells.
// Depends on nothing.
package ouis_pkg;

   localparam int CAPACITY = 16;
   localparam int SYM_W    = 8;
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int COUNT_W  = 5;
   localparam int STATUS_W = 2;

   typedef enum logic [1:0] {
      REQ_INSERT = 2'd0,
      REQ_REMOVE = 2'd1,
      REQ_CLEAR  = 2'd2,
      REQ_LIST   = 2'd3
   } req_kind_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_CHANGED  = 2'd0,
      ST_NOCHANGE = 2'd1,
      ST_FULL     = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_LOAD,
      CELL_REMOVE,
      CELL_ROTATE
   } cell_op_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_LIST
   } fsm_state_type;

   typedef struct packed {
      cell_op_type             cell_op;
      logic [SYM_W-1:0]        symbol;
      logic [CNT_W-1:0]        count;
      logic                    rsp_load;
      status_type              rsp_status;
      logic                    rsp_entry_valid;
      logic                    rsp_last;
      logic [COUNT_W-1:0]      rsp_count;
   } ctrl_type;

endpackage

// ----- hw/rtl/ouis_cell.sv -----
// One cell of the set chain: holds a single stored index and takes part in
// search, append, compaction on removal and rotation for listing. Uses ouis_pkg.
module ouis_cell (
   input  logic                      clock,
   input  logic [ouis_pkg::IDX_W-1:0] idx,
   input  ouis_pkg::cell_op_type     cell_op,
   input  logic [ouis_pkg::SYM_W-1:0] symbol,
   input  logic [ouis_pkg::CNT_W-1:0] count,
   input  logic [ouis_pkg::SYM_W-1:0] next_entry,
   input  logic [ouis_pkg::SYM_W-1:0] head_entry,
   input  logic                      hit_in,
   output logic                      hit_out,
   output logic [ouis_pkg::SYM_W-1:0] entry
);
   import ouis_pkg::*;

   logic [SYM_W-1:0] entry_ff;
   logic [SYM_W-1:0] entry_in;
   logic [CNT_W-1:0] idx_ext;
   logic             valid;
   logic             is_tail;

   assign idx_ext = CNT_W'(idx);
   assign valid   = idx_ext < count;
   assign is_tail = idx_ext == (count - CNT_W'(1));
   assign hit_out = hit_in | (valid && (entry_ff == symbol));
   assign entry   = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      unique case (cell_op)
         CELL_HOLD: entry_in = entry_ff;
         CELL_LOAD: begin
            if (idx_ext == count) entry_in = symbol;
         end
         // Every cell at or after the match takes its neighbour's index.
         CELL_REMOVE: begin
            if (hit_out) entry_in = next_entry;
         end
         // The occupied part of the chain turns by one place; the tail takes the head.
         CELL_ROTATE: begin
            if (valid) entry_in = is_tail ? head_entry : next_entry;
         end
         default: entry_in = entry_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

// ----- hw/rtl/ouis_ctrl.sv -----
// Sequencer for the ordered unique index set: holds the request, the fill count
// and the listing counter, and drives the cell chain and result register. Uses ouis_pkg.
module ouis_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [1:0]                req_kind,
   input  logic [ouis_pkg::SYM_W-1:0] req_symbol,
   input  logic                      any_match,
   input  logic                      out_free,
   output ouis_pkg::ctrl_type        ctrl
);
   import ouis_pkg::*;

   fsm_state_type    state_ff, state_in;
   req_kind_type     op_ff;
   logic [SYM_W-1:0] symbol_ff;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] remain_ff, remain_in;

   assign req_ready = (state_ff == S_IDLE);

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_EXEC;
         end
         S_EXEC: begin
            if (out_free) begin
               state_in = ((op_ff == REQ_LIST) && (count_ff != '0)) ? S_LIST : S_IDLE;
            end
         end
         S_LIST: begin
            if (out_free && (remain_ff == CNT_W'(1))) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Outputs and datapath updates.
   always_comb begin
      count_in             = count_ff;
      remain_in            = remain_ff;
      ctrl.cell_op         = CELL_HOLD;
      ctrl.symbol          = symbol_ff;
      ctrl.count           = count_ff;
      ctrl.rsp_load        = 1'b0;
      ctrl.rsp_status      = ST_NOCHANGE;
      ctrl.rsp_entry_valid = 1'b0;
      ctrl.rsp_last        = 1'b1;
      unique case (state_ff)
         S_IDLE: ;
         S_EXEC: begin
            if (out_free) begin
               unique case (op_ff)
                  REQ_INSERT: begin
                     ctrl.rsp_load = 1'b1;
                     if (any_match) begin
                        ctrl.rsp_status = ST_NOCHANGE;
                     end else if (count_ff == CNT_W'(CAPACITY)) begin
                        ctrl.rsp_status = ST_FULL;
                     end else begin
                        ctrl.rsp_status = ST_CHANGED;
                        ctrl.cell_op    = CELL_LOAD;
                        count_in        = count_ff + CNT_W'(1);
                     end
                  end
                  REQ_REMOVE: begin
                     ctrl.rsp_load = 1'b1;
                     if (any_match) begin
                        ctrl.rsp_status = ST_CHANGED;
                        ctrl.cell_op    = CELL_REMOVE;
                        count_in        = count_ff - CNT_W'(1);
                     end
                  end
                  REQ_CLEAR: begin
                     ctrl.rsp_load   = 1'b1;
                     ctrl.rsp_status = (count_ff != '0) ? ST_CHANGED : ST_NOCHANGE;
                     count_in        = '0;
                  end
                  REQ_LIST: begin
                     // An empty set answers at once; otherwise the listing pass starts.
                     ctrl.rsp_load = (count_ff == '0);
                     remain_in     = count_ff;
                  end
                  default: ;
               endcase
            end
         end
         S_LIST: begin
            if (out_free) begin
               ctrl.rsp_load        = 1'b1;
               ctrl.rsp_entry_valid = 1'b1;
               ctrl.rsp_last        = (remain_ff == CNT_W'(1));
               ctrl.cell_op         = CELL_ROTATE;
               remain_in            = remain_ff - CNT_W'(1);
            end
         end
         default: ;
      endcase
      ctrl.rsp_count = COUNT_W'(count_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      remain_ff <= remain_in;
      if (req_valid && req_ready) begin
         op_ff     <= req_kind_type'(req_kind);
         symbol_ff <= req_symbol;
      end
   end

endmodule

// ----- hw/rtl/ordered_unique_index_set_unit.sv -----
// Top level of the ordered unique index set: sequencer, chain of cells and
// result register. Uses ouis_pkg, ouis_ctrl and ouis_cell.
//
//   channel  direction  tdata                          tuser
//   req_     in         symbol[7:0]                    req_type[1:0]
//   rsp_     out        entry[7:0], count[12:8]        status[1:0], entry_valid[2]
//
// Insert, remove and clear are accepted in the idle state; the chain is then
// searched and updated in the execute state once the result register is free.
// A list request turns the chain one place per result as cell 0 is read out,
// one result per stored index. Reset empties the set at once. A stalled result
// holds the sequencer; one result register separates the chain from the output.
module ordered_unique_index_set_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,  // symbol[7:0]
   input  logic [1:0]  req_tuser,  // req_type[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,  // entry[7:0], count[12:8], zero[15:13]
   output logic [2:0]  rsp_tuser,  // status[1:0], entry_valid[2]
   output logic        rsp_tlast
);
   import ouis_pkg::*;

   ctrl_type           ctrl;
   logic               out_free;
   logic [CAPACITY:0]  hit;
   logic [SYM_W-1:0]   cell_entry [CAPACITY];
   logic [SYM_W-1:0]   next_entry [CAPACITY];

   logic               rsp_valid_ff;
   status_type         rsp_status_ff;
   logic [SYM_W-1:0]   rsp_entry_ff;
   logic               rsp_entry_valid_ff;
   logic               rsp_last_ff;
   logic [COUNT_W-1:0] rsp_count_ff;

   assign out_free = !rsp_valid_ff || rsp_tready;

   ouis_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req_kind   (req_tuser),
      .req_symbol (req_tdata),
      .any_match  (hit[CAPACITY]),
      .out_free   (out_free),
      .ctrl       (ctrl)
   );

   assign hit[0] = 1'b0;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      if (i == CAPACITY - 1) begin : g_end
         assign next_entry[i] = '0;
      end else begin : g_mid
         assign next_entry[i] = cell_entry[i+1];
      end

      ouis_cell u_cell (
         .clock      (clock),
         .idx        (IDX_W'(i)),
         .cell_op    (ctrl.cell_op),
         .symbol     (ctrl.symbol),
         .count      (ctrl.count),
         .next_entry (next_entry[i]),
         .head_entry (cell_entry[0]),
         .hit_in     (hit[i]),
         .hit_out    (hit[i+1]),
         .entry      (cell_entry[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctrl.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.rsp_load) begin
         rsp_status_ff      <= ctrl.rsp_status;
         rsp_entry_ff       <= ctrl.rsp_entry_valid ? cell_entry[0] : '0;
         rsp_entry_valid_ff <= ctrl.rsp_entry_valid;
         rsp_last_ff        <= ctrl.rsp_last;
         rsp_count_ff       <= ctrl.rsp_count;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_count_ff, rsp_entry_ff};
   assign rsp_tuser  = {rsp_entry_valid_ff, rsp_status_ff};
   assign rsp_tlast  = rsp_last_ff;

endmodule
